/* rtl/core/wmprs_pkg.sv */
// ----------------------------------------------------------------------------
// Window mean predictor package
// Shared widths, register indexes, reset values and the sequencer state type
// for the windowed mean predictor with RMS surprise.
// ----------------------------------------------------------------------------
package wmprs_pkg;

   // Squared-error accumulator width and its saturation value.
   localparam int ACC_W = 40;
   localparam logic [ACC_W-1:0] ACC_LIMIT = '1;

   // Error magnitudes at or above 2^SQ_LIM square to the saturation value.
   localparam int SQ_LIM = 20;

   // Quotient bits produced per cycle by the shared divider.
   localparam int DIV_STEP = 8;

   // Result field width.
   localparam int OUT_W = 16;

   // Configuration register widths and the port shape.
   localparam int WINLEN_W   = 5;
   localparam int VECLEN_W   = 7;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 7;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_VECTOR_LENGTH = 2'd1;

   // Register reset values.
   localparam logic [WINLEN_W-1:0] WINLEN_RESET = 5'd16;
   localparam logic [VECLEN_W-1:0] VECLEN_RESET = 7'd64;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PDIV,
      ST_ERR,
      ST_SQ,
      ST_ACC,
      ST_MDIV,
      ST_SQRT,
      ST_EMIT
   } state_type;

endpackage

/* rtl/core/window_mean_predictor_rms_surprise_top.sv */
// ----------------------------------------------------------------------------
// Windowed mean predictor with RMS surprise
// Streams vector elements, predicts each one from the mean of the last vectors
// held, and reports the RMS prediction error once per vector.
// ----------------------------------------------------------------------------
// Samples arrive one element per beat; every vector_length-th beat closes a
// vector and produces one result beat with the RMS error of that vector
// against the windowed mean (or zero with no_history set while the window is
// empty). Each element reads the window-sum and history RAMs; while the
// window holds vectors its window sum is then divided by the held count in
// the prediction divider, which yields 8 quotient bits per cycle, and its
// error is squared and accumulated before the next element is accepted.
// While the window holds vectors the closing element adds a pass of the same
// divider for the mean square and the bit-serial square root; the result
// register then loads once the previous result is taken. Reset and every
// write to either register start a clearing pass that zeroes all DIM_MAX
// window sums and takes no sample. Registers may be written only while no
// vector is in progress and no result is outstanding.
module window_mean_predictor_rms_surprise_top #(
   parameter int WINDOW_MAX  = 16,
   parameter int DIM_MAX     = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Sample stream.
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // sample
   // Result stream.
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [wmprs_pkg::OUT_W-1:0]             rsp_tdata,  // surprise
   output logic                                    rsp_tuser,  // no_history
   // Register writes.
   input  logic                                    csr_wen,
   input  logic [wmprs_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [wmprs_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import wmprs_pkg::*;

   localparam int HELD_W      = $clog2(WINDOW_MAX + 1);
   localparam int SLOT_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int DIM_W       = $clog2(DIM_MAX + 1);
   localparam int POS_W       = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam int HIST_DEPTH  = WINDOW_MAX * DIM_MAX;
   localparam int HIST_AW     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int SUM_W       = SAMPLE_BITS + HELD_W;
   localparam int MAG_W       = SUM_W;
   localparam int ERR_W       = SAMPLE_BITS + 2;
   localparam int SQ_IN_W     = (ERR_W < SQ_LIM) ? ERR_W : SQ_LIM;
   localparam int DVS_W       = (HELD_W > DIM_W) ? HELD_W : DIM_W;
   localparam int PRED_ROUNDS = (MAG_W + DIV_STEP - 1) / DIV_STEP;
   localparam int MEAN_ROUNDS = (ACC_W + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_ROUNDS  = (PRED_ROUNDS > MEAN_ROUNDS) ? PRED_ROUNDS : MEAN_ROUNDS;
   localparam int DIV_W       = DIV_ROUNDS * DIV_STEP;
   localparam int PRED_SHIFT  = DIV_W - PRED_ROUNDS * DIV_STEP;
   localparam int MEAN_SHIFT  = DIV_W - MEAN_ROUNDS * DIV_STEP;
   localparam int RCNT_W      = $clog2(DIV_ROUNDS + 1);
   localparam int ROOT_W      = ACC_W / 2;
   localparam int SREM_W      = ROOT_W + 2;
   localparam int SCNT_W      = $clog2(ROOT_W + 1);

   // Sequencer and configuration.
   state_type               state_ff, state_in;
   logic [WINLEN_W-1:0]     winlen_ff;
   logic [VECLEN_W-1:0]     veclen_ff;
   logic                    cfg_hit;

   // Window bookkeeping.
   logic [HELD_W-1:0]       held_ff;
   logic [SLOT_W-1:0]       oldest_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [POS_W-1:0]        clr_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic [HELD_W-1:0]       win_eff;
   logic [DIM_W-1:0]        dim_eff;
   logic                    full;
   logic                    last;
   logic [SLOT_W-1:0]       slot;
   logic [HIST_AW-1:0]      hist_addr;

   // Memories and their read registers.
   logic signed [SUM_W-1:0]       sum_mem [DIM_MAX];
   logic [SAMPLE_BITS-1:0]        hist_mem [HIST_DEPTH];
   logic signed [SUM_W-1:0]       sum_rd_ff;
   logic signed [SAMPLE_BITS-1:0] hist_rd_ff;
   logic                          sum_we;
   logic [POS_W-1:0]              sum_waddr;
   logic signed [SUM_W-1:0]       sum_wdata;
   logic                          hist_we;

   // Per-element datapath.
   logic                          accept;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          full_ff;
   logic [HIST_AW-1:0]            hist_addr_ff;
   logic signed [SAMPLE_BITS-1:0] hist_sub;
   logic signed [SUM_W-1:0]       sum_new;
   logic [MAG_W-1:0]              sum_u;
   logic [MAG_W-1:0]              sum_mag;
   logic                          sneg_ff;
   logic signed [ERR_W-1:0]       x_ext;
   logic signed [ERR_W-1:0]       pred_mag;
   logic signed [ERR_W-1:0]       err;
   logic [ERR_W-1:0]              err_abs;
   logic [ERR_W-1:0]              a_ff;
   logic [SQ_IN_W-1:0]            a_lo;
   logic [2*SQ_IN_W-1:0]          sq_prod;
   logic [ACC_W-1:0]              sq_ff;
   logic [ACC_W:0]                acc_sum;
   logic [ACC_W-1:0]              acc_next;

   // Shared divider.
   logic [DIV_W-1:0]        div_num_ff;
   logic [DVS_W-1:0]        div_rem_ff;
   logic [DVS_W-1:0]        div_dvs_ff;
   logic [RCNT_W-1:0]       div_cnt_ff;
   logic [DIV_W-1:0]        div_num_c;
   logic [DVS_W-1:0]        div_rem_c;
   logic [DVS_W:0]          div_trial;

   // Square root.
   logic [ACC_W-1:0]        rad_ff;
   logic [ROOT_W-1:0]       root_ff;
   logic [SREM_W-1:0]       srem_ff;
   logic [SCNT_W-1:0]       scnt_ff;
   logic [SREM_W-1:0]       s_cand;
   logic [SREM_W-1:0]       s_trial;

   // Result register.
   logic                    rsp_tvalid_ff;
   logic [OUT_W-1:0]        rsp_tdata_ff;
   logic                    rsp_tuser_ff;
   logic                    rsp_free;
   logic                    emit;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   // A write to a known register clears the history.
   assign cfg_hit = csr_wen && ((csr_addr == REG_WINDOW_LENGTH) ||
                                (csr_addr == REG_VECTOR_LENGTH));

   // Clamp the registers to their usable ranges.
   always_comb begin
      if (winlen_ff == '0) begin
         win_eff = HELD_W'(1);
      end else if (32'(winlen_ff) > WINDOW_MAX) begin
         win_eff = HELD_W'(WINDOW_MAX);
      end else begin
         win_eff = HELD_W'(winlen_ff);
      end
      if (veclen_ff == '0) begin
         dim_eff = DIM_W'(1);
      end else if (32'(veclen_ff) > DIM_MAX) begin
         dim_eff = DIM_W'(DIM_MAX);
      end else begin
         dim_eff = DIM_W'(veclen_ff);
      end
   end

   // The new vector takes the oldest slot once the window is full, else the
   // next free one (the oldest slot stays at zero until the window fills).
   assign full      = held_ff >= win_eff;
   assign last      = (DIM_W'(pos_ff) + DIM_W'(1)) >= dim_eff;
   assign slot      = full ? oldest_ff : SLOT_W'(held_ff);
   assign hist_addr = HIST_AW'(slot) * HIST_AW'(DIM_MAX) + HIST_AW'(pos_ff);

   // Window sum update: add the new element, drop the one it replaces.
   assign hist_sub = full_ff ? hist_rd_ff : '0;
   assign sum_new  = sum_rd_ff + SUM_W'(x_ff) - SUM_W'(hist_sub);
   assign sum_u    = sum_rd_ff;
   assign sum_mag  = sum_rd_ff[SUM_W-1] ? (~sum_u + MAG_W'(1)) : sum_u;

   // Prediction error from the truncated quotient and the sign of the sum.
   assign x_ext    = ERR_W'(x_ff);
   assign pred_mag = signed'({2'b00, div_num_ff[SAMPLE_BITS-1:0]});
   assign err      = sneg_ff ? (x_ext + pred_mag) : (x_ext - pred_mag);
   assign err_abs  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
   assign a_lo     = a_ff[SQ_IN_W-1:0];
   assign sq_prod  = a_lo * a_lo;

   // Saturating accumulate.
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, sq_ff};
   assign acc_next = acc_sum[ACC_W] ? ACC_LIMIT : acc_sum[ACC_W-1:0];

   // Divider round: DIV_STEP restoring steps; the remainder stays below the
   // divisor, so it needs only the divisor's width.
   always_comb begin
      div_rem_c = div_rem_ff;
      div_num_c = div_num_ff;
      div_trial = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         div_trial = {div_rem_c, div_num_c[DIV_W-1]};
         div_num_c = {div_num_c[DIV_W-2:0], 1'b0};
         if (div_trial >= {1'b0, div_dvs_ff}) begin
            div_rem_c    = DVS_W'(div_trial - {1'b0, div_dvs_ff});
            div_num_c[0] = 1'b1;
         end else begin
            div_rem_c = div_trial[DVS_W-1:0];
         end
      end
   end

   // Square root step: bring down two radicand bits, try root*4+1.
   assign s_cand  = {srem_ff[SREM_W-3:0], rad_ff[ACC_W-1 -: 2]};
   assign s_trial = {root_ff, 2'b01};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == POS_W'(DIM_MAX - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = (held_ff != '0) ? ST_PDIV : ST_ACC;
         end
         ST_PDIV: begin
            if (div_cnt_ff == RCNT_W'(1)) state_in = ST_ERR;
         end
         ST_ERR: state_in = ST_SQ;
         ST_SQ:  state_in = ST_ACC;
         ST_ACC: begin
            if (!last) begin
               state_in = ST_IDLE;
            end else if (held_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MDIV;
            end
         end
         ST_MDIV: begin
            if (div_cnt_ff == RCNT_W'(1)) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (scnt_ff == SCNT_W'(1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
      if (cfg_hit) state_in = ST_CLEAR;
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      sum_we     = 1'b0;
      sum_waddr  = pos_ff;
      sum_wdata  = sum_new;
      hist_we    = 1'b0;
      emit       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            sum_we    = 1'b1;
            sum_waddr = clr_ff;
            sum_wdata = '0;
         end
         ST_IDLE: req_tready = !csr_wen;
         ST_READ: begin
            sum_we  = 1'b1;
            hist_we = 1'b1;
         end
         ST_EMIT: emit = rsp_free;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Window-sum and history RAMs; reads issue on accept and land in READ,
   // writes happen only in READ or while clearing, so no access overlaps.
   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
      if (accept) sum_rd_ff <= sum_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_addr_ff] <= x_ff;
      if (accept) hist_rd_ff <= hist_mem[hist_addr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         winlen_ff <= WINLEN_RESET;
         veclen_ff <= VECLEN_RESET;
         held_ff   <= '0;
         oldest_ff <= '0;
         pos_ff    <= '0;
         acc_ff    <= '0;
         clr_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (cfg_hit) begin
            if (csr_addr == REG_WINDOW_LENGTH) winlen_ff <= csr_wdata[WINLEN_W-1:0];
            else veclen_ff <= csr_wdata[VECLEN_W-1:0];
            held_ff   <= '0;
            oldest_ff <= '0;
            pos_ff    <= '0;
            acc_ff    <= '0;
            clr_ff    <= '0;
         end else begin
            if (state_ff == ST_CLEAR) clr_ff <= clr_ff + POS_W'(1);
            if (state_ff == ST_ACC) begin
               acc_ff <= acc_next;
               if (!last) pos_ff <= pos_ff + POS_W'(1);
            end
            // The finished vector joins the window once its result is out.
            if (emit) begin
               pos_ff <= '0;
               acc_ff <= '0;
               if (full) begin
                  if (HELD_W'(oldest_ff) + HELD_W'(1) == win_eff) oldest_ff <= '0;
                  else oldest_ff <= oldest_ff + SLOT_W'(1);
               end else begin
                  held_ff <= held_ff + HELD_W'(1);
               end
            end
         end
      end
   end

   // Element datapath, divider and square root.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff         <= req_tdata[SAMPLE_BITS-1:0];
         full_ff      <= full;
         hist_addr_ff <= hist_addr;
      end
      case (state_ff)
         ST_READ: begin
            sq_ff      <= '0;
            sneg_ff    <= sum_rd_ff[SUM_W-1];
            div_num_ff <= DIV_W'(sum_mag) << PRED_SHIFT;
            div_rem_ff <= '0;
            div_dvs_ff <= DVS_W'(held_ff);
            div_cnt_ff <= RCNT_W'(PRED_ROUNDS);
         end
         ST_PDIV: begin
            div_num_ff <= div_num_c;
            div_rem_ff <= div_rem_c;
            div_cnt_ff <= div_cnt_ff - RCNT_W'(1);
         end
         ST_ERR: a_ff <= err_abs;
         ST_SQ: begin
            if ((a_ff >> SQ_LIM) != '0) sq_ff <= ACC_LIMIT;
            else sq_ff <= ACC_W'(sq_prod);
         end
         ST_ACC: begin
            div_num_ff <= DIV_W'(acc_next) << MEAN_SHIFT;
            div_rem_ff <= '0;
            div_dvs_ff <= DVS_W'(dim_eff);
            div_cnt_ff <= RCNT_W'(MEAN_ROUNDS);
         end
         ST_MDIV: begin
            div_num_ff <= div_num_c;
            div_rem_ff <= div_rem_c;
            div_cnt_ff <= div_cnt_ff - RCNT_W'(1);
            rad_ff     <= div_num_c[ACC_W-1:0];
            root_ff    <= '0;
            srem_ff    <= '0;
            scnt_ff    <= SCNT_W'(ROOT_W);
         end
         ST_SQRT: begin
            rad_ff  <= {rad_ff[ACC_W-3:0], 2'b00};
            scnt_ff <= scnt_ff - SCNT_W'(1);
            if (s_cand >= s_trial) begin
               srem_ff <= s_cand - s_trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_ff <= s_cand;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   // Result register: loads once per vector, holds until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tuser_ff <= (held_ff == '0);
         if (held_ff == '0) rsp_tdata_ff <= '0;
         else if ((root_ff >> OUT_W) != '0) rsp_tdata_ff <= '1;
         else rsp_tdata_ff <= root_ff[OUT_W-1:0];
      end
   end

`ifndef SYNTHESIS
   // The window never holds more vectors than its length.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= win_eff)
      else $error("vector count exceeds the window length");

   // The ring only rotates once the window is full.
   a_oldest_full: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff != '0) |-> (held_ff == win_eff))
      else $error("oldest slot moved before the window filled");

   // The element position stays inside the vector.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      DIM_W'(pos_ff) < dim_eff)
      else $error("element position beyond vector length");

   // The divider never runs with a zero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PDIV) || (state_ff == ST_MDIV)) |-> (div_dvs_ff != '0))
      else $error("divider started with zero divisor");

   // A result beat appears only out of the result state.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result beat raised outside the result state");
`endif

endmodule
